// ----- rtl/spc_pkg.sv -----
package spc_pkg;

	// result status codes
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_FEW  = 3'd2;
	localparam logic [2:0] ST_TIME = 3'd3;
	localparam logic [2:0] ST_ZVAR = 3'd4;
	localparam logic [2:0] ST_OVF  = 3'd5;

	// correlation of +1.0 in Q1.30
	localparam logic [30:0] CORR_ONE = 31'h4000_0000;

	// shared unit operations
	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} unit_op_t;

	// request from sequencer to the shared unit
	typedef struct packed {
		logic         start;
		unit_op_t     op;
		logic [127:0] a;
		logic [63:0]  b;
		logic [6:0]   steps;
	} unit_req_t;

	// answer of the shared unit
	typedef struct packed {
		logic         done;
		logic [127:0] res;
	} unit_rsp_t;

	// one result item
	typedef struct packed {
		logic [31:0]        sample_count;
		logic signed [31:0] mean_x;
		logic signed [31:0] mean_y;
		logic [62:0]        var_x;
		logic [62:0]        var_y;
		logic [31:0]        std_x;
		logic [31:0]        std_y;
		logic signed [63:0] cov_xy;
		logic signed [31:0] corr_xy;
		logic [2:0]         status;
	} res_t;

endpackage

// ----- rtl/spc_in_if.sv -----
interface spc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_sample;
	logic signed [31:0] y_sample;
	logic [62:0]        x_time;
	logic [62:0]        y_time;
	logic               last;

	modport source(output valid, output x_sample, output y_sample, output x_time,
		output y_time, output last, input ready);
	modport sink(input valid, input x_sample, input y_sample, input x_time,
		input y_time, input last, output ready);
endinterface

// ----- rtl/spc_out_if.sv -----
interface spc_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        sample_count;
	logic signed [31:0] mean_x;
	logic signed [31:0] mean_y;
	logic [62:0]        var_x;
	logic [62:0]        var_y;
	logic [31:0]        std_x;
	logic [31:0]        std_y;
	logic signed [63:0] cov_xy;
	logic signed [31:0] corr_xy;
	logic [2:0]         status;

	modport source(output valid, output sample_count, output mean_x, output mean_y,
		output var_x, output var_y, output std_x, output std_y, output cov_xy,
		output corr_xy, output status, input ready);
	modport sink(input valid, input sample_count, input mean_x, input mean_y,
		input var_x, input var_y, input std_x, input std_y, input cov_xy,
		input corr_xy, input status, output ready);
endinterface

// ----- rtl/spc_unit.sv -----
// Shared shift/add unit: one product, quotient or root bit per cycle.
module spc_unit import spc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	unit_op_t     op_q;
	logic         busy_q;
	logic         done_q;
	logic [6:0]   cnt_q;
	logic [63:0]  b_q;
	logic [127:0] n_q;
	logic [127:0] q_q;
	logic [65:0]  acc_q;
	logic [67:0]  add_a;
	logic [67:0]  add_b;
	logic [67:0]  sum;
	logic         add_sub;
	logic         ge;

	// operand select for the single adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (op_q)
			OP_MUL: begin
				add_a = {4'd0, acc_q[63:0]};
				add_b = n_q[0] ? {4'd0, b_q} : '0;
			end
			OP_DIV: begin
				add_a   = {3'd0, acc_q[63:0], n_q[127]};
				add_b   = {4'd0, b_q};
				add_sub = 1'b1;
			end
			OP_SQRT: begin
				add_a   = {acc_q, n_q[127:126]};
				add_b   = {2'd0, q_q[63:0], 2'b01};
				add_sub = 1'b1;
			end
			default: ;
		endcase
		sum = add_a + (add_sub ? ~add_b : add_b) + {67'd0, add_sub};
		ge  = ~sum[67];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			b_q   <= req.b;
			n_q   <= (req.op == OP_MUL) ? {64'd0, req.a[63:0]} : req.a;
			acc_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					acc_q <= {2'd0, sum[64:1]};
					n_q   <= {64'd0, sum[0], n_q[63:1]};
				end
				OP_DIV: begin
					acc_q <= ge ? {2'd0, sum[63:0]} : {2'd0, acc_q[62:0], n_q[127]};
					q_q   <= {q_q[126:0], ge};
					n_q   <= {n_q[126:0], 1'b0};
				end
				OP_SQRT: begin
					acc_q <= ge ? sum[65:0] : add_a[65:0];
					q_q   <= {q_q[126:0], ge};
					n_q   <= {n_q[125:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == OP_MUL) ? {acc_q[63:0], n_q[63:0]} : q_q;

endmodule

// ----- rtl/spc_seq.sv -----
// Sequencer: running statistics and the steps of one item on the shared unit.
module spc_seq import spc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_sample,
	input  logic signed [31:0] y_sample,
	input  logic [62:0]        x_time,
	input  logic [62:0]        y_time,
	input  logic               last,
	input  logic               out_busy,
	output logic               emit,
	output res_t               res,
	output unit_req_t          req,
	input  unit_rsp_t          rsp
);

	typedef enum logic [14:0] {
		S_IDLE = 15'h0001,
		S_DIVX = 15'h0002,
		S_DIVY = 15'h0004,
		S_MULX = 15'h0008,
		S_MULY = 15'h0010,
		S_MULC = 15'h0020,
		S_VARX = 15'h0040,
		S_VARY = 15'h0080,
		S_STDX = 15'h0100,
		S_STDY = 15'h0200,
		S_COV  = 15'h0400,
		S_PROD = 15'h0800,
		S_ROOT = 15'h1000,
		S_CORR = 15'h2000,
		S_EMIT = 15'h4000
	} state_t;

	state_t             state_q;
	logic               launched_q;
	logic [31:0]        cnt_q;
	logic signed [47:0] mx_q;
	logic signed [47:0] my_q;
	logic signed [63:0] dsx_q;
	logic signed [63:0] dsy_q;
	logic signed [63:0] cdv_q;
	logic [2:0]         err_q;
	logic signed [47:0] xv_q;
	logic signed [47:0] yv_q;
	logic signed [48:0] dx_q;
	logic signed [48:0] dy_q;
	logic               last_q;
	logic [62:0]        vx_q;
	logic [62:0]        vy_q;
	logic [31:0]        sx_q;
	logic [31:0]        sy_q;
	logic               sat_q;
	logic signed [63:0] cv_q;
	logic signed [31:0] cr_q;
	logic [2:0]         st_q;
	logic [127:0]       prod_q;
	logic [62:0]        root_q;

	logic signed [48:0] ex;
	logic signed [48:0] ey;
	logic [48:0]        dx_mag;
	logic [48:0]        dy_mag;
	logic [48:0]        ex_mag;
	logic [48:0]        ey_mag;
	logic [63:0]        cdv_mag;
	logic [31:0]        nm1;
	logic               big_x;
	logic               big_y;
	logic               use_unit;
	logic [2:0]         err_acc;
	logic [48:0]        mean_base;
	logic [48:0]        mean_dlt;
	logic [48:0]        mean_new;
	logic [63:0]        sum_base;
	logic [63:0]        term;
	logic               term_neg;
	logic [64:0]        sadd;
	logic [93:0]        cq;
	logic [30:0]        cmag;
	logic [2:0]         st_norm;

	function automatic logic [48:0] mag49(input logic [48:0] v);
		return v[48] ? 49'(-v) : v;
	endfunction

	// saturating 64-bit add, overflow flag on top
	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		logic [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			r = b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			r = s[63:0];
		return {s[64] ^ s[63], r};
	endfunction

	// deviations against the updated means
	assign ex      = {xv_q[47], xv_q} - {mx_q[47], mx_q};
	assign ey      = {yv_q[47], yv_q} - {my_q[47], my_q};
	assign dx_mag  = mag49(dx_q);
	assign dy_mag  = mag49(dy_q);
	assign ex_mag  = mag49(ex);
	assign ey_mag  = mag49(ey);
	assign cdv_mag = cdv_q[63] ? 64'(-cdv_q) : cdv_q;
	assign nm1     = cnt_q - 32'd1;
	assign big_x   = vx_q[62:48] != '0;
	assign big_y   = vy_q[62:48] != '0;

	// error code after the timestamp check and count step of a new item
	always_comb begin
		err_acc = err_q;
		if (x_time != y_time)
			err_acc = ST_TIME;
		if (cnt_q == '1 && err_acc == ST_OK)
			err_acc = ST_OVF;
	end

	// mean update from the quotient
	always_comb begin
		mean_base = (state_q == S_DIVX) ? {mx_q[47], mx_q} : {my_q[47], my_q};
		mean_dlt  = ((state_q == S_DIVX) ? dx_q[48] : dy_q[48]) ?
			49'(-rsp.res[48:0]) : rsp.res[48:0];
		mean_new  = mean_base + mean_dlt;
	end

	// deviation sum update from the product
	always_comb begin
		case (state_q)
			S_MULX: begin
				sum_base = dsx_q;
				term_neg = dx_q[48] ^ ex[48];
			end
			S_MULY: begin
				sum_base = dsy_q;
				term_neg = dy_q[48] ^ ey[48];
			end
			default: begin
				sum_base = cdv_q;
				term_neg = dx_q[48] ^ ey[48];
			end
		endcase
		term = term_neg ? 64'(-{14'd0, rsp.res[97:48]}) : {14'd0, rsp.res[97:48]};
		sadd = sat_add(sum_base, term);
	end

	// correlation clamp and normal status
	always_comb begin
		cq      = rsp.res[93:0];
		cmag    = (cq > {63'd0, CORR_ONE}) ? CORR_ONE : cq[30:0];
		if (err_q == ST_OVF || sat_q)
			st_norm = ST_OVF;
		else if (dsx_q == '0 || dsy_q == '0)
			st_norm = ST_ZVAR;
		else
			st_norm = ST_OK;
	end

	// shared unit request per step
	always_comb begin
		req       = '0;
		req.op    = OP_MUL;
		req.steps = 7'd64;
		case (state_q)
			S_DIVX: begin
				req.op = OP_DIV; req.a = {dx_mag, 79'd0}; req.b = {32'd0, cnt_q};
				req.steps = 7'd49;
			end
			S_DIVY: begin
				req.op = OP_DIV; req.a = {dy_mag, 79'd0}; req.b = {32'd0, cnt_q};
				req.steps = 7'd49;
			end
			S_MULX: begin
				req.a = {79'd0, dx_mag}; req.b = {15'd0, ex_mag};
			end
			S_MULY: begin
				req.a = {79'd0, dy_mag}; req.b = {15'd0, ey_mag};
			end
			S_MULC: begin
				req.a = {79'd0, dx_mag}; req.b = {15'd0, ey_mag};
			end
			S_VARX: begin
				req.op = OP_DIV; req.a = {dsx_q[62:0], 65'd0}; req.b = {32'd0, nm1};
				req.steps = 7'd63;
			end
			S_VARY: begin
				req.op = OP_DIV; req.a = {dsy_q[62:0], 65'd0}; req.b = {32'd0, nm1};
				req.steps = 7'd63;
			end
			S_STDX: begin
				req.op = OP_SQRT; req.a = {vx_q[47:0], 16'd0, 64'd0}; req.steps = 7'd32;
			end
			S_STDY: begin
				req.op = OP_SQRT; req.a = {vy_q[47:0], 16'd0, 64'd0}; req.steps = 7'd32;
			end
			S_COV: begin
				req.op = OP_DIV; req.a = {cdv_mag, 64'd0}; req.b = {32'd0, nm1};
			end
			S_PROD: begin
				req.a = {64'd0, dsx_q}; req.b = dsy_q;
			end
			S_ROOT: begin
				req.op = OP_SQRT; req.a = prod_q;
			end
			S_CORR: begin
				req.op = OP_DIV; req.a = {cdv_mag, 64'd0}; req.b = {1'b0, root_q};
				req.steps = 7'd94;
			end
			default: ;
		endcase
		use_unit = !(state_q == S_IDLE || state_q == S_EMIT ||
			(state_q == S_STDX && big_x) || (state_q == S_STDY && big_y));
		req.start = use_unit && !launched_q;
	end

	assign in_ready = (state_q == S_IDLE);
	assign emit     = (state_q == S_EMIT) && !out_busy;

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launched_q <= 1'b0;
			cnt_q      <= '0;
			mx_q       <= '0;
			my_q       <= '0;
			dsx_q      <= '0;
			dsy_q      <= '0;
			cdv_q      <= '0;
			err_q      <= ST_OK;
		end else begin
			if (req.start)
				launched_q <= 1'b1;
			else if (rsp.done)
				launched_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					err_q <= err_acc;
					if (cnt_q != '1)
						cnt_q <= cnt_q + 32'd1;
					state_q <= S_DIVX;
				end
				S_DIVX: if (rsp.done) begin
					mx_q    <= mean_new[47:0];
					state_q <= S_DIVY;
				end
				S_DIVY: if (rsp.done) begin
					my_q    <= mean_new[47:0];
					state_q <= S_MULX;
				end
				S_MULX: if (rsp.done) begin
					dsx_q <= sadd[63:0];
					if (sadd[64] && err_q == ST_OK)
						err_q <= ST_OVF;
					state_q <= S_MULY;
				end
				S_MULY: if (rsp.done) begin
					dsy_q <= sadd[63:0];
					if (sadd[64] && err_q == ST_OK)
						err_q <= ST_OVF;
					state_q <= S_MULC;
				end
				S_MULC: if (rsp.done) begin
					cdv_q <= sadd[63:0];
					if (sadd[64] && err_q == ST_OK)
						err_q <= ST_OVF;
					if (!last_q)
						state_q <= S_IDLE;
					else if (cnt_q < 32'd2)
						state_q <= S_EMIT;
					else
						state_q <= S_VARX;
				end
				S_VARX: if (rsp.done) state_q <= S_VARY;
				S_VARY: if (rsp.done) state_q <= S_STDX;
				S_STDX: if (big_x || rsp.done) state_q <= S_STDY;
				S_STDY: if (big_y || rsp.done) begin
					state_q <= (err_q == ST_TIME) ? S_EMIT : S_COV;
				end
				S_COV: if (rsp.done) begin
					state_q <= (dsx_q != '0 && dsy_q != '0) ? S_PROD : S_EMIT;
				end
				S_PROD: if (rsp.done) state_q <= S_ROOT;
				S_ROOT: if (rsp.done) state_q <= S_CORR;
				S_CORR: if (rsp.done) state_q <= S_EMIT;
				S_EMIT: if (!out_busy) begin
					cnt_q   <= '0;
					mx_q    <= '0;
					my_q    <= '0;
					dsx_q   <= '0;
					dsy_q   <= '0;
					cdv_q   <= '0;
					err_q   <= ST_OK;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and per-run results
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) begin
				xv_q   <= {x_sample, 16'd0};
				yv_q   <= {y_sample, 16'd0};
				dx_q   <= {x_sample[31], x_sample, 16'd0} - {mx_q[47], mx_q};
				dy_q   <= {y_sample[31], y_sample, 16'd0} - {my_q[47], my_q};
				last_q <= last;
				vx_q   <= '0;
				vy_q   <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				sat_q  <= 1'b0;
				cv_q   <= '0;
				cr_q   <= '0;
				st_q   <= ST_FEW;
			end
			S_VARX: if (rsp.done) vx_q <= rsp.res[62:0];
			S_VARY: if (rsp.done) vy_q <= rsp.res[62:0];
			S_STDX: begin
				if (big_x) begin
					sx_q  <= '1;
					sat_q <= 1'b1;
				end else if (rsp.done) begin
					sx_q <= rsp.res[31:0];
				end
			end
			S_STDY: begin
				if (big_y) begin
					sy_q  <= '1;
					sat_q <= 1'b1;
				end else if (rsp.done) begin
					sy_q <= rsp.res[31:0];
				end
				if ((big_y || rsp.done) && err_q == ST_TIME)
					st_q <= ST_TIME;
			end
			S_COV: if (rsp.done) begin
				cv_q <= cdv_q[63] ? 64'(-rsp.res[63:0]) : rsp.res[63:0];
				st_q <= st_norm;
			end
			S_PROD: if (rsp.done) prod_q <= rsp.res;
			S_ROOT: if (rsp.done) root_q <= rsp.res[62:0];
			S_CORR: if (rsp.done) cr_q <= cdv_q[63] ? 32'(-{1'b0, cmag}) : {1'b0, cmag};
			default: ;
		endcase
	end

	// result view
	always_comb begin
		res.sample_count = cnt_q;
		res.mean_x       = mx_q[47:16];
		res.mean_y       = my_q[47:16];
		res.var_x        = vx_q;
		res.var_y        = vy_q;
		res.std_x        = sx_q;
		res.std_y        = sy_q;
		res.cov_xy       = cv_q;
		res.corr_xy      = cr_q;
		res.status       = st_q;
	end

endmodule

// ----- rtl/streaming_pair_correlation_core.sv -----
// Streaming pair correlation. Each input item is one (x, y) Q16.16 pair with
// timestamps; it updates running means, squared-deviation sums and the
// co-deviation sum (Welford). The item with last set returns one result item
// (count, means, sample variances, standard deviations, covariance, Pearson
// correlation in Q1.30, status) and clears the run. All arithmetic runs on one
// shift/add unit that yields one product, quotient or root bit per cycle, so
// the block takes one item at a time: a plain item takes two mean divisions
// and three products, and the item that closes a run of two or more pairs
// adds variance, root, covariance, product, 128-bit root and correlation
// division steps. A finished result sits
// in an output register, so the next item is taken while it waits.
module streaming_pair_correlation_core import spc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	spc_in_if.sink    in_ch,
	spc_out_if.source out_ch
);

	unit_req_t req;
	unit_rsp_t rsp;
	res_t      res;
	res_t      out_q;
	logic      out_valid_q;
	logic      emit;
	logic      out_busy;

	assign out_busy = out_valid_q && !out_ch.ready;

	spc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.x_sample (in_ch.x_sample),
		.y_sample (in_ch.y_sample),
		.x_time   (in_ch.x_time),
		.y_time   (in_ch.y_time),
		.last     (in_ch.last),
		.out_busy (out_busy),
		.emit     (emit),
		.res      (res),
		.req      (req),
		.rsp      (rsp)
	);

	spc_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_count = out_q.sample_count;
	assign out_ch.mean_x       = out_q.mean_x;
	assign out_ch.mean_y       = out_q.mean_y;
	assign out_ch.var_x        = out_q.var_x;
	assign out_ch.var_y        = out_q.var_y;
	assign out_ch.std_x        = out_q.std_x;
	assign out_ch.std_y        = out_q.std_y;
	assign out_ch.cov_xy       = out_q.cov_xy;
	assign out_ch.corr_xy      = out_q.corr_xy;
	assign out_ch.status       = out_q.status;

endmodule

// ----- rtl/spc_chk.sv -----
// Port-level checks of the correlation core.
module spc_chk import spc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic [2:0]         status,
	input logic [62:0]        var_x,
	input logic signed [63:0] cov_xy,
	input logic signed [31:0] corr_xy
);

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// a result only appears after work, never out of idle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FEW || status == ST_TIME ||
			status == ST_ZVAR || status == ST_OVF))
		else $error("undefined status code");

	// short run carries no spread figures
	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FEW |-> var_x == '0 && cov_xy == '0 && corr_xy == '0)
		else $error("short run with nonzero statistics");

	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> corr_xy <= 32'sd1073741824 && corr_xy >= -32'sd1073741824)
		else $error("correlation beyond +-1.0");

endmodule

bind streaming_pair_correlation_core spc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.status    (out_ch.status),
	.var_x     (out_ch.var_x),
	.cov_xy    (out_ch.cov_xy),
	.corr_xy   (out_ch.corr_xy)
);
